// File: rtl/core/srte_pkg.sv
// Shared types and constants for the selective-repeat transfer engine.
// No dependencies.
`timescale 1ns / 1ps
package srte_pkg;

  localparam int MAX_PACKETS_DEF = 64;
  localparam int WINDOW_MAX_DEF  = 16;
  localparam int BYTES_PER_PKT   = 1024;
  localparam int MAX_RESULTS     = 16;
  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_TICK  = 3'd1,
    OP_ACK   = 3'd2,
    OP_NAK   = 3'd3,
    OP_DATA  = 3'd4,
    OP_READ  = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    EV_SEND     = 2'd0,
    EV_ACK      = 2'd1,
    EV_COMPLETE = 2'd2,
    EV_READ     = 2'd3
  } event_t;

  typedef enum logic [2:0] {
    CFG_TOTAL   = 3'd0,
    CFG_BYTES   = 3'd1,
    CFG_FILL    = 3'd2,
    CFG_WINDOW  = 3'd3,
    CFG_RETX    = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_NEWSEND,
    ST_ACKSLIDE,
    ST_EMIT1,
    ST_COMPLETE,
    ST_RDWAIT
  } state_t;

  // One classified command handed from front to back.
  typedef struct packed {
    opcode_t     op;
    logic [31:0] seq;
    logic [31:0] payload;
    logic        seq_small;   // seq fits the packet index range
  } cmd_t;

endpackage

// File: rtl/core/srte_if.sv
// Valid/ready channel interfaces for the engine's input and result items.
// Depends on nothing.
`timescale 1ns / 1ps
interface srte_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [31:0] seq_num;
  logic signed [31:0] payload_value;
  modport source (output valid, opcode, seq_num, payload_value, input ready);
  modport sink   (input valid, opcode, seq_num, payload_value, output ready);
endinterface

interface srte_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [5:0]  out_seq;
  logic signed [31:0] out_value;
  logic        last_of_run;
  modport source (output valid, event_kind, out_seq, out_value, last_of_run, input ready);
  modport sink   (input valid, event_kind, out_seq, out_value, last_of_run, output ready);
endinterface

// File: rtl/core/selective_repeat_transfer_engine.sv
// Selective-repeat transfer engine, top level: front queue plus back sequencer.
// A start takes effect as it leaves the queue; a read passes the read-wait state; nak and data
// pass the emit and completion states; an ack slides the window step by step, then completes.
// A tick walks every timer row through the single timer memory port in the scan state,
// and stalls while the result register is full. Results leave one per cycle at most.
// Reset (rst_n, synchronous, low) restores register defaults and clears all packet state.
`timescale 1ns / 1ps
module selective_repeat_transfer_engine #(
  parameter int MAX_PACKETS = srte_pkg::MAX_PACKETS_DEF,
  parameter int WINDOW_MAX  = srte_pkg::WINDOW_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  srte_in_if.sink     in_ch,
  srte_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import srte_pkg::*;

  // The front end takes items and holds them in a two-entry queue, so the upstream
  // side can still hand over up to two items while the back end walks timers.
  cmd_t q_data;
  logic q_valid, q_pop;

  srte_front #(.PKT_W($clog2(MAX_PACKETS))) u_front (
    .clk, .rst_n, .in_ch, .q_data, .q_valid, .q_pop
  );

  // The back end owns all packet state and the output register.
  srte_back #(.MAX_PACKETS(MAX_PACKETS), .WINDOW_MAX(WINDOW_MAX)) u_back (
    .clk, .rst_n, .q_data, .q_valid, .q_pop, .cfg_we, .cfg_index, .cfg_wdata, .out_ch
  );
endmodule

// File: rtl/core/srte_front.sv
// Front end: accepts input items, classifies them and queues them for the back end.
// Depends on srte_pkg and srte_if.
`timescale 1ns / 1ps
module srte_front #(
  parameter int PKT_W = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  srte_in_if.sink       in_ch,
  output srte_pkg::cmd_t q_data,
  output logic          q_valid,
  input  logic          q_pop
);
  import srte_pkg::*;

  cmd_t       mem_r [QUEUE_DEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  cmd_t       c;

  assign in_ch.ready = (cnt_r != 2'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_data      = mem_r[rp_r];

  always_comb begin
    c.op        = opcode_t'(in_ch.opcode);
    c.seq       = in_ch.seq_num;
    c.payload   = in_ch.payload_value;
    c.seq_small = (in_ch.seq_num >> PKT_W) == 32'd0;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= c;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push)  wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'(QUEUE_DEPTH))
    else $error("queue overflow");
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'(QUEUE_DEPTH)) |-> !in_ch.ready) else $error("ready while full");
endmodule

// File: rtl/core/srte_back.sv
// Back end: protocol state, per-packet memories, timer scan and result sequencing.
// Depends on srte_pkg and srte_if.
`timescale 1ns / 1ps
module srte_back #(
  parameter int MAX_PACKETS = srte_pkg::MAX_PACKETS_DEF,
  parameter int WINDOW_MAX  = srte_pkg::WINDOW_MAX_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  srte_pkg::cmd_t q_data,
  input  logic           q_valid,
  output logic           q_pop,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_wdata,
  srte_out_if.source     out_ch
);
  import srte_pkg::*;

  localparam int PW = $clog2(MAX_PACKETS);
  localparam int CW = $clog2(MAX_PACKETS + 1);

  // Configuration registers.
  logic [6:0]  total_r;
  logic [16:0] bytes_r;
  logic [31:0] fill_r;
  logic [4:0]  win_r;
  logic [15:0] retx_r;

  // Per-packet flags: valid bits cleared at reset and on start.
  logic [MAX_PACKETS-1:0] acked_r, infl_r, recv_r;
  // Memories (timers rows valid by tvalid bit, values by recv bit).
  logic [15:0] tmr_mem [MAX_PACKETS];
  logic [31:0] val_mem [MAX_PACKETS];
  logic [MAX_PACKETS-1:0] tval_r;

  logic [CW-1:0] next_r, low_r, high_r, used_r;
  logic started_r, completed_r, lastd_r;

  state_t      st_r, st_nxt;
  cmd_t        cmd_r;
  logic [PW-1:0] idx_r;
  logic [4:0]  resends_r;
  logic [15:0] tmr_rd_r;
  logic [31:0] val_rd_r;

  // Output register.
  logic        ov_r;
  logic [1:0]  okind_r;
  logic [5:0]  oseq_r;
  logic [31:0] oval_r;
  logic        olast_r;
  // The held-back result is the final one of its item and still has to go out.
  logic        tail_r;

  logic        out_free;
  assign out_free = !ov_r || out_ch.ready;

  assign out_ch.valid       = ov_r;
  assign out_ch.event_kind  = okind_r;
  assign out_ch.out_seq     = oseq_r;
  assign out_ch.out_value   = oval_r;
  assign out_ch.last_of_run = olast_r;

  logic [15:0] tload;
  assign tload = (retx_r == 16'd0) ? 16'd1 : retx_r;

  logic [CW-1:0] seqc;
  logic          seq_in;
  logic [PW-1:0] sidx;
  assign sidx   = cmd_r.seq[PW-1:0];
  assign seqc   = CW'(cmd_r.seq[PW-1:0]);
  assign seq_in = cmd_r.seq_small && (seqc < used_r);

  logic [PW-1:0] lastidx;
  assign lastidx = PW'(used_r - CW'(1));
  logic compl_ok;
  assign compl_ok = started_r && !completed_r && lastd_r && (used_r != '0) && acked_r[lastidx];

  // Start-time sizing.
  logic [7:0]    pk_bytes;
  logic [CW-1:0] pk_sz;
  logic [4:0]    w_eff;
  always_comb begin
    pk_bytes = 8'((18'(bytes_r) + 18'(BYTES_PER_PKT - 1)) >> 10);
    if (total_r != 7'd0) pk_sz = (32'(total_r) > MAX_PACKETS) ? CW'(MAX_PACKETS) : CW'(total_r);
    else pk_sz = (32'(pk_bytes) > MAX_PACKETS) ? CW'(MAX_PACKETS) : CW'(pk_bytes);
    w_eff = (win_r == 5'd0) ? 5'd1 : win_r;
    if (32'(w_eff) > WINDOW_MAX) w_eff = 5'(WINDOW_MAX);
  end

  // Scan step helpers.
  logic scan_last;
  assign scan_last = (32'(idx_r) == MAX_PACKETS - 1);
  logic due;
  assign due = tval_r[idx_r] && (tmr_rd_r == 16'd1) && !acked_r[idx_r]
               && (CW'(idx_r) < used_r) && (resends_r < 5'(MAX_RESULTS - 1));
  logic ns_go;
  logic [PW-1:0] nidx;
  assign nidx  = PW'(next_r);
  assign ns_go = started_r && (next_r >= low_r) && (next_r <= high_r) && (next_r < used_r);

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:     if (q_valid && !tail_r) begin
        case (q_data.op)
          OP_TICK:  st_nxt = ST_CLEAR;
          OP_ACK:   st_nxt = ST_ACKSLIDE;
          OP_NAK, OP_DATA: st_nxt = ST_EMIT1;
          OP_READ:  st_nxt = ST_RDWAIT;
          default:  st_nxt = ST_IDLE;
        endcase
      end
      ST_CLEAR:    st_nxt = ST_SCAN;
      ST_SCAN:     if (out_free && scan_last) st_nxt = ST_NEWSEND;
      ST_NEWSEND:  if (out_free) st_nxt = ST_IDLE;
      ST_ACKSLIDE: if (!(low_r < used_r && acked_r[PW'(low_r)])) st_nxt = ST_COMPLETE;
      ST_EMIT1:    if (out_free) st_nxt = ST_COMPLETE;
      ST_COMPLETE: if (out_free) st_nxt = ST_IDLE;
      ST_RDWAIT:   if (out_free) st_nxt = ST_IDLE;
      default:     st_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: queue pop.
  always_comb begin
    q_pop = (st_r == ST_IDLE) && q_valid && !tail_r;
  end

  // Pending-result tracking for last_of_run within an item.
  logic        pend_r;
  logic [1:0]  pkind_r;
  logic [5:0]  pseq_r;
  logic [31:0] pval_r;

  logic        emit;
  logic [1:0]  ekind;
  logic [5:0]  eseq;
  logic [31:0] eval;
  logic        flush;
  always_comb begin
    emit = 1'b0; ekind = EV_SEND; eseq = '0; eval = '0; flush = 1'b0;
    case (st_r)
      ST_SCAN: if (out_free && due) begin
        emit = 1'b1; ekind = EV_SEND; eseq = 6'(idx_r); eval = fill_r;
      end
      ST_NEWSEND: if (out_free) begin
        flush = 1'b1;
        if (ns_go && !acked_r[nidx] && !infl_r[nidx]) begin
          emit = 1'b1; ekind = EV_SEND; eseq = 6'(next_r); eval = fill_r;
        end
      end
      ST_EMIT1: if (out_free) begin
        if (cmd_r.op == OP_NAK && seq_in && !acked_r[sidx]) begin
          emit = 1'b1; ekind = EV_SEND; eseq = 6'(cmd_r.seq); eval = fill_r;
        end else if (cmd_r.op == OP_DATA && seq_in) begin
          emit = 1'b1; ekind = EV_ACK; eseq = 6'(cmd_r.seq); eval = cmd_r.payload;
        end
      end
      ST_COMPLETE: if (out_free) begin
        flush = 1'b1;
        if (compl_ok) begin
          emit = 1'b1; ekind = EV_COMPLETE;
        end
      end
      ST_RDWAIT: if (out_free) begin
        flush = 1'b1; emit = 1'b1; ekind = EV_READ; eseq = 6'(cmd_r.seq);
        eval = (cmd_r.seq_small && recv_r[sidx]) ? val_rd_r : 32'd0;
      end
      default: ;
    endcase
  end

  // One result is held back so the final one of an item can be marked. When the
  // closing step produces a result while another is held, the held one goes out
  // first and the new one follows as the final result on the next free cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0; pend_r <= 1'b0; tail_r <= 1'b0;
    end else begin
      if (out_ch.ready) ov_r <= 1'b0;
      if (tail_r) begin
        if (out_free) begin
          ov_r <= 1'b1; okind_r <= pkind_r; oseq_r <= pseq_r; oval_r <= pval_r;
          olast_r <= 1'b1; pend_r <= 1'b0; tail_r <= 1'b0;
        end
      end else if (emit) begin
        if (pend_r) begin
          ov_r <= 1'b1; okind_r <= pkind_r; oseq_r <= pseq_r; oval_r <= pval_r;
          olast_r <= 1'b0;
        end
        if (flush && pend_r) begin
          pend_r <= 1'b1; pkind_r <= ekind; pseq_r <= eseq; pval_r <= eval;
          tail_r <= 1'b1;
        end else if (flush) begin
          ov_r <= 1'b1; okind_r <= ekind; oseq_r <= eseq; oval_r <= eval; olast_r <= 1'b1;
          pend_r <= 1'b0;
        end else begin
          pend_r <= 1'b1; pkind_r <= ekind; pseq_r <= eseq; pval_r <= eval;
        end
      end else if (flush && pend_r) begin
        ov_r <= 1'b1; okind_r <= pkind_r; oseq_r <= pseq_r; oval_r <= pval_r;
        olast_r <= 1'b1; pend_r <= 1'b0;
      end
    end
  end

  // Memory read ports (registered).
  logic [PW-1:0] rd_idx;
  logic [PW-1:0] vrd_idx;
  always_comb begin
    rd_idx = idx_r;
    if (st_r == ST_IDLE) rd_idx = '0;
    else if (st_r == ST_SCAN && out_free) rd_idx = PW'(idx_r + PW'(1));
  end
  assign vrd_idx = (st_r == ST_IDLE) ? q_data.seq[PW-1:0] : cmd_r.seq[PW-1:0];
  always_ff @(posedge clk) begin
    tmr_rd_r <= tmr_mem[rd_idx];
    val_rd_r <= val_mem[vrd_idx];
  end

  // Memory writes: one timer port, one value port.
  logic          tw_en;
  logic [PW-1:0] tw_idx;
  logic [15:0]   tw_dat;
  always_comb begin
    tw_en = 1'b0; tw_idx = idx_r; tw_dat = tload;
    if (st_r == ST_SCAN && out_free && tval_r[idx_r]) begin
      tw_en = 1'b1;
      // A timer that is due but over the burst cap stays at one.
      if (tmr_rd_r > 16'd1) tw_dat = tmr_rd_r - 16'd1;
      else if (due) tw_dat = tload;
      else tw_dat = tmr_rd_r;
    end else if (st_r == ST_NEWSEND && emit) begin
      tw_en = 1'b1; tw_idx = nidx;
    end else if (st_r == ST_EMIT1 && emit && cmd_r.op == OP_NAK) begin
      tw_en = 1'b1; tw_idx = sidx;
    end
  end
  always_ff @(posedge clk) begin
    if (tw_en) tmr_mem[tw_idx] <= tw_dat;
    if (st_r == ST_EMIT1 && out_free && cmd_r.op == OP_DATA && seq_in && !recv_r[sidx])
      val_mem[sidx] <= cmd_r.payload;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      total_r <= 7'd3; bytes_r <= 17'd1024; fill_r <= 32'd1; win_r <= 5'd16; retx_r <= 16'd2000;
      acked_r <= '0; infl_r <= '0; recv_r <= '0; tval_r <= '0;
      next_r <= '0; low_r <= '0; high_r <= '0; used_r <= '0;
      started_r <= 1'b0; completed_r <= 1'b0; lastd_r <= 1'b0;
      idx_r <= '0; resends_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TOTAL:  total_r <= cfg_wdata[6:0];
          CFG_BYTES:  bytes_r <= cfg_wdata[16:0];
          CFG_FILL:   fill_r  <= cfg_wdata;
          CFG_WINDOW: win_r   <= cfg_wdata[4:0];
          CFG_RETX:   retx_r  <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (q_pop) begin
        cmd_r <= q_data;
        idx_r <= '0; resends_r <= '0;
        if (q_data.op == OP_START && !started_r) begin
          started_r <= 1'b1; completed_r <= 1'b0; lastd_r <= 1'b0;
          used_r <= pk_sz;
          acked_r <= '0; infl_r <= '0; recv_r <= '0; tval_r <= '0;
          next_r <= '0; low_r <= '0;
          if (pk_sz == '0) high_r <= '0;
          else if (CW'(w_eff) > pk_sz) high_r <= pk_sz - CW'(1);
          else high_r <= CW'(w_eff) - CW'(1);
        end
      end
      case (st_r)
        ST_SCAN: if (out_free) begin
          if (tval_r[idx_r] && tmr_rd_r <= 16'd1) begin
            if (acked_r[idx_r] || CW'(idx_r) >= used_r) tval_r[idx_r] <= 1'b0;
            else if (due) begin
              infl_r[idx_r] <= 1'b1; resends_r <= resends_r + 5'd1;
            end
          end
          if (tval_r[idx_r] && tmr_rd_r > 16'd1) tval_r[idx_r] <= 1'b1;
          idx_r <= idx_r + PW'(1);
        end
        ST_NEWSEND: if (out_free && ns_go) begin
          if (emit) begin infl_r[nidx] <= 1'b1; tval_r[nidx] <= 1'b1; end
          next_r <= next_r + CW'(1);
        end
        ST_ACKSLIDE: begin
          if (low_r < used_r && acked_r[PW'(low_r)]) begin
            low_r <= low_r + CW'(1);
            if (high_r < used_r - CW'(1)) high_r <= high_r + CW'(1);
          end
        end
        ST_EMIT1: if (out_free) begin
          if (emit && cmd_r.op == OP_NAK) begin
            infl_r[sidx] <= 1'b1; tval_r[sidx] <= 1'b1;
          end
          if (cmd_r.op == OP_DATA && seq_in && !recv_r[sidx]) begin
            recv_r[sidx] <= 1'b1;
            if (seqc == used_r - CW'(1)) lastd_r <= 1'b1;
          end
        end
        ST_COMPLETE: if (out_free && compl_ok) begin
          completed_r <= 1'b1; tval_r <= '0;
        end
        default: ;
      endcase
      // An ack marks its packet as it leaves the queue, so the slide sees it.
      if (q_pop && q_data.op == OP_ACK && q_data.seq_small
          && CW'(q_data.seq[PW-1:0]) < used_r) begin
        acked_r[q_data.seq[PW-1:0]] <= 1'b1;
        infl_r[q_data.seq[PW-1:0]]  <= 1'b0;
        tval_r[q_data.seq[PW-1:0]]  <= 1'b0;
      end
    end
  end

  a_low_le_used: assert property (@(posedge clk) disable iff (!rst_n) low_r <= used_r)
    else $error("window base past packet count");
  a_acked_not_infl: assert property (@(posedge clk) disable iff (!rst_n)
    (acked_r & infl_r) == '0) else $error("packet both acked and in flight");
  a_complete_once: assert property (@(posedge clk) disable iff (!rst_n)
    $past(completed_r) |-> completed_r) else $error("completion flag dropped");
  a_resend_cap: assert property (@(posedge clk) disable iff (!rst_n)
    resends_r <= 5'(MAX_RESULTS - 1)) else $error("too many resends in one tick");
endmodule
